@@ rtl/core/ftc_pkg.sv @@
package ftc_pkg;

   // Track buffer geometry (TRACK_BYTES is a power of two)
   localparam int TRACK_BYTES = 4096;
   localparam int TRACK_AW    = $clog2(TRACK_BYTES);
   localparam int COUNT_W     = $clog2(TRACK_BYTES + 1);

   // Stepper geometry
   localparam int MAX_HALF_TRACK   = 80;
   localparam int HALF_TRACK_RESET = 2 * 40;
   localparam int HT_W             = 7;

   // Latch byte bit positions
   localparam int LATCH_DRIVE0 = 4;
   localparam int LATCH_FLUX   = 5;
   localparam int LATCH_WGATE  = 6;
   localparam int LATCH_DRIVE1 = 7;

   localparam logic [7:0] READ_IDLE  = 8'hFF;
   localparam logic [7:0] READ_FLAG  = 8'h80;
   localparam logic [7:0] READ_CLEAR = 8'h00;

   typedef enum logic [2:0] {
      KIND_LATCH   = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_STATUS  = 3'd2,
      KIND_PROTECT = 3'd3,
      KIND_FILL    = 3'd4,
      KIND_FETCH   = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic [11:0] index;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        track_request;
      logic        flush_request;
      logic        drive_valid;
      logic        drive_number;
      logic [5:0]  track_number;
      logic [11:0] flush_start;
      logic [12:0] flush_count;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [TRACK_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                rd_en;
      logic [TRACK_AW-1:0] rd_addr;
   } mem_req_type;

   // Keep the odd cells (bits 14, 12, ..., 0) of a shifted cell pair word
   function automatic logic [7:0] odd_cells(input logic [15:0] cells);
      logic [7:0] b;
      for (int k = 0; k < 8; k++) begin
         b[k] = cells[2 * k];
      end
      return b;
   endfunction

   // Map a host buffer position onto the track buffer
   function automatic logic [TRACK_AW-1:0] track_addr(input logic [11:0] index);
      return TRACK_AW'(index);
   endfunction

endpackage

@@ rtl/core/ftc_if.sv @@
interface ftc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  value;
   logic [11:0] index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface ftc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        track_request;
   logic        flush_request;
   logic        drive_valid;
   logic        drive_number;
   logic [5:0]  track_number;
   logic [11:0] flush_start;
   logic [12:0] flush_count;

   modport source (output valid, output read_data, output track_request,
                   output flush_request, output drive_valid, output drive_number,
                   output track_number, output flush_start, output flush_count,
                   input ready);
   modport sink   (input valid, input read_data, input track_request,
                   input flush_request, input drive_valid, input drive_number,
                   input track_number, input flush_start, input flush_count,
                   output ready);
endinterface

@@ rtl/core/ftc_ram.sv @@
module ftc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ftc_engine.sv @@
module ftc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ftc_pkg::req_type     item,
   input  logic [7:0]          mem_rdata,
   output ftc_pkg::mem_req_type mem_req,
   output ftc_pkg::rsp_type     result,
   output logic                result_fetch
);
   import ftc_pkg::*;

   logic [HT_W-1:0]     half_track_ff [2];
   logic [HT_W-1:0]     half_track_in [2];
   logic                drive_on_ff, drive_on_in;
   logic                drive_sel_ff, drive_sel_in;
   logic [7:0]          prev_latch_ff, prev_latch_in;
   logic [15:0]         shift_ff, shift_in;
   logic [3:0]          bit_count_ff, bit_count_in;
   logic                cell_phase_ff, cell_phase_in;
   logic [TRACK_AW-1:0] byte_pos_ff, byte_pos_in;
   logic [COUNT_W-1:0]  write_count_ff, write_count_in;
   logic [TRACK_AW-1:0] write_start_ff, write_start_in;
   logic                ready_ff, ready_in;
   logic                load_pend_ff, load_pend_in;

   logic [15:0] shift_eff;

   // Buffer byte loaded by the previous data read lands in the shifter now
   assign shift_eff = load_pend_ff ? {8'h00, mem_rdata} : shift_ff;

   // Update the controller state for one beat and form its result
   always_comb begin
      logic            nv;
      logic            nd;
      logic [HT_W-1:0] ht;
      logic [15:0]     sh;
      logic [3:0]      bc;
      logic            cp;
      logic [7:0]      diff;
      logic            ph_ok;
      logic            up_hit;
      logic            dn_hit;
      logic [15:0]     sh16;
      logic [HT_W-1:0] trk;

      nv     = 1'b0;
      nd     = 1'b0;
      ht     = '0;
      sh     = '0;
      bc     = '0;
      cp     = 1'b0;
      diff   = prev_latch_ff ^ item.value;
      ph_ok  = (item.value[3:0] == 4'b0001) || (item.value[3:0] == 4'b0010) ||
               (item.value[3:0] == 4'b0100) || (item.value[3:0] == 4'b1000);
      up_hit = |({item.value[2:0], item.value[3]} & prev_latch_ff[3:0]);
      dn_hit = |({item.value[0], item.value[3:1]} & prev_latch_ff[3:0]);
      sh16   = '0;
      trk    = '0;

      half_track_in  = half_track_ff;
      drive_on_in    = drive_on_ff;
      drive_sel_in   = drive_sel_ff;
      prev_latch_in  = prev_latch_ff;
      shift_in       = shift_eff;
      bit_count_in   = bit_count_ff;
      cell_phase_in  = cell_phase_ff;
      byte_pos_in    = byte_pos_ff;
      write_count_in = write_count_ff;
      write_start_in = write_start_ff;
      ready_in       = ready_ff;
      load_pend_in   = 1'b0;

      mem_req      = '0;
      result       = '0;
      result.read_data = READ_IDLE;
      result_fetch = 1'b0;

      if (accept) begin
         case (item.kind)
            KIND_LATCH: begin
               // Drive select, load request on a new selection
               nv = item.value[LATCH_DRIVE0] | item.value[LATCH_DRIVE1];
               nd = ~item.value[LATCH_DRIVE0];
               if ((nv != drive_on_ff) || (nv && (nd != drive_sel_ff))) begin
                  drive_on_in  = nv;
                  drive_sel_in = nv & nd;
                  if (nv) begin
                     result.track_request = 1'b1;
                     byte_pos_in          = '0;
                     write_count_in       = '0;
                  end
               end
               if (drive_on_in) begin
                  // Step the head, load on landing at an even half-track
                  ht = half_track_ff[drive_sel_in];
                  if (ph_ok && up_hit) begin
                     if (ht != '0) begin
                        ht = ht - 1'b1;
                     end
                     if (!ht[0]) begin
                        result.track_request = 1'b1;
                        byte_pos_in          = '0;
                        write_count_in       = '0;
                     end
                  end else if (ph_ok && dn_hit) begin
                     if (ht < HT_W'(MAX_HALF_TRACK)) begin
                        ht = ht + 1'b1;
                     end
                     if (!ht[0]) begin
                        result.track_request = 1'b1;
                        byte_pos_in          = '0;
                        write_count_in       = '0;
                     end
                  end
                  half_track_in[drive_sel_in] = ht;

                  // Shift in one cell, store a byte every eight cell pairs
                  if (!item.value[LATCH_WGATE]) begin
                     sh            = {shift_eff[14:0], diff[LATCH_FLUX]};
                     shift_in      = sh;
                     cp            = ~cell_phase_ff;
                     cell_phase_in = cp;
                     if (!cp) begin
                        bc = bit_count_ff - 1'b1;
                        if (bc == '0) begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = byte_pos_in;
                           mem_req.wr_data = odd_cells(sh);
                           byte_pos_in     = byte_pos_in + 1'b1;
                           if (write_count_in < COUNT_W'(TRACK_BYTES)) begin
                              write_count_in = write_count_in + 1'b1;
                           end
                           bc = 4'd8;
                        end
                        bit_count_in = bc;
                     end
                  end

                  // Write gate edges: falling marks the start, rising flags a flush
                  if (diff[LATCH_WGATE]) begin
                     if (prev_latch_ff[LATCH_WGATE]) begin
                        write_start_in = byte_pos_in;
                        cell_phase_in  = 1'b0;
                     end else if (write_count_in != '0) begin
                        result.flush_request = 1'b1;
                        result.flush_start   = 12'(write_start_ff);
                        result.flush_count   = 13'(write_count_in);
                     end
                     bit_count_in   = 4'd8;
                     write_count_in = '0;
                  end
               end
               prev_latch_in = item.value;
            end
            KIND_DATA: begin
               // Serialize track bits, fetch the next byte when the shifter runs dry
               bc = bit_count_ff;
               if (bc != '0) begin
                  if (ready_ff) begin
                     bc = bc - 1'b1;
                  end
                  sh16             = shift_eff >> bc;
                  result.read_data = sh16[7:0];
               end
               if (bc == '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = byte_pos_ff;
                  load_pend_in    = 1'b1;
                  if (ready_ff) begin
                     bc          = 4'd8;
                     byte_pos_in = byte_pos_ff + 1'b1;
                  end
                  ready_in = 1'b0;
               end
               bit_count_in = bc;
            end
            KIND_STATUS: begin
               if (drive_on_ff) begin
                  ready_in = 1'b1;
               end
               result.read_data = ready_in ? READ_FLAG : READ_CLEAR;
            end
            KIND_PROTECT: begin
               result.read_data = drive_on_ff ? READ_FLAG : READ_IDLE;
            end
            KIND_FILL: begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = track_addr(item.index);
               mem_req.wr_data = item.value;
            end
            KIND_FETCH: begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = track_addr(item.index);
               result_fetch    = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Drive status after this beat
      result.drive_valid  = drive_on_in;
      result.drive_number = drive_on_in & drive_sel_in;
      if (drive_on_in) begin
         trk                 = half_track_in[drive_sel_in];
         result.track_number = trk[HT_W-1:1];
      end
   end

   // Hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         half_track_ff[0] <= HT_W'(HALF_TRACK_RESET);
         half_track_ff[1] <= HT_W'(HALF_TRACK_RESET);
         drive_on_ff      <= 1'b0;
         drive_sel_ff     <= 1'b0;
         prev_latch_ff    <= '0;
         shift_ff         <= '0;
         bit_count_ff     <= 4'd8;
         cell_phase_ff    <= 1'b0;
         byte_pos_ff      <= '0;
         write_count_ff   <= '0;
         write_start_ff   <= '0;
         ready_ff         <= 1'b0;
         load_pend_ff     <= 1'b0;
      end else begin
         half_track_ff    <= half_track_in;
         drive_on_ff      <= drive_on_in;
         drive_sel_ff     <= drive_sel_in;
         prev_latch_ff    <= prev_latch_in;
         shift_ff         <= shift_in;
         bit_count_ff     <= bit_count_in;
         cell_phase_ff    <= cell_phase_in;
         byte_pos_ff      <= byte_pos_in;
         write_count_ff   <= write_count_in;
         write_start_ff   <= write_start_in;
         ready_ff         <= ready_in;
         load_pend_ff     <= load_pend_in;
      end
   end

endmodule

@@ rtl/core/ftc_outq.sv @@
module ftc_outq (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  ftc_pkg::rsp_type in_data,
   input  logic            in_fetch,
   input  logic [7:0]      mem_rdata,
   output logic            in_ready,
   output logic            out_valid,
   output ftc_pkg::rsp_type out_data,
   input  logic            out_ready
);
   import ftc_pkg::*;

   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff, s2_data_in;
   logic    s2_fetch_ff, s2_fetch_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    s2_move;

   // Advance the read stage when the output register is free or being taken
   assign s2_move  = s2_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s2_valid_ff || s2_move;

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_data_in   = s2_data_ff;
      s2_fetch_in  = s2_fetch_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (s2_move) begin
         s2_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_data_in  = s2_data_ff;
         if (s2_fetch_ff) begin
            out_data_in.read_data = mem_rdata;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         s2_valid_in = 1'b1;
         s2_data_in  = in_data;
         s2_fetch_in = in_fetch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s2_data_ff  <= s2_data_in;
      s2_fetch_ff <= s2_fetch_in;
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/core/stepper_floppy_track_controller.sv @@
// Floppy track controller: drive select, half-track stepper and write shifter
// of a two-drive floppy port, with the track buffer in one synchronous RAM.
//
// req_ch carries one bus access per beat (kind, value, index): latch write,
// data read, status read, protect read, buffer fill or buffer fetch. rsp_ch
// returns exactly one result beat per request beat, in order: the byte read,
// the track load and flush requests, and the selected drive and track.
//
// A request beat is taken every cycle while the result side keeps up. The
// result beat is registered in the read stage, which waits out the registered
// read of the track RAM, and then in the output register, which holds the beat.
// When rsp_ch stalls, the output register and the read stage hold their beats
// and req_ch.ready drops once both are full; nothing is lost.
//
// Reset (synchronous, active high) puts both heads at half-track 80, selects
// no drive, and empties the pipeline. The track RAM is not cleared; host
// fills (or written bytes) must precede any read of a buffer position.
module stepper_floppy_track_controller (
   input  logic      clock,
   input  logic      reset,
   ftc_req_if.sink   req_ch,
   ftc_rsp_if.source rsp_ch
);
   import ftc_pkg::*;

   logic        accept;
   logic        in_ready;
   req_type     item;
   mem_req_type mem_req;
   logic [7:0]  mem_rdata;
   rsp_type     s1_result;
   logic        s1_fetch;
   logic        out_valid;
   rsp_type     out_data;

   assign req_ch.ready = in_ready;
   assign accept       = req_ch.valid & in_ready;

   assign item.kind  = kind_type'(req_ch.kind);
   assign item.value = req_ch.value;
   assign item.index = req_ch.index;

   ftc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item         (item),
      .mem_rdata    (mem_rdata),
      .mem_req      (mem_req),
      .result       (s1_result),
      .result_fetch (s1_fetch)
   );

   ftc_ram #(
      .WIDTH (8),
      .DEPTH (TRACK_BYTES)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   ftc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_data   (s1_result),
      .in_fetch  (s1_fetch),
      .mem_rdata (mem_rdata),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.valid         = out_valid;
   assign rsp_ch.read_data     = out_data.read_data;
   assign rsp_ch.track_request = out_data.track_request;
   assign rsp_ch.flush_request = out_data.flush_request;
   assign rsp_ch.drive_valid   = out_data.drive_valid;
   assign rsp_ch.drive_number  = out_data.drive_number;
   assign rsp_ch.track_number  = out_data.track_number;
   assign rsp_ch.flush_start   = out_data.flush_start;
   assign rsp_ch.flush_count   = out_data.flush_count;

endmodule

@@ rtl/core/ftc_checker.sv @@
module ftc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  read_data,
   input logic        flush_request,
   input logic        drive_valid,
   input logic        drive_number,
   input logic [5:0]  track_number,
   input logic [11:0] flush_start,
   input logic [12:0] flush_count
);
   import ftc_pkg::*;

   logic [2:0] pending_ff, pending_in;

   // Count request beats not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No result beat without an open request, and never more than two in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0) && (pending_ff <= 3'd2))
      else $error("result beat without matching request or too many in flight");

   // A stalled result beat holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(flush_start)
                                  && $stable(flush_count) && $stable(track_number))
      else $error("stalled result beat changed");

   // A flush always reports written bytes; otherwise the flush fields are clear
   a_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (flush_request ? (flush_count != '0)
                                   : ((flush_count == '0) && (flush_start == '0))))
      else $error("flush fields inconsistent");

   // Without a selected drive the drive fields read zero; the head stays in range
   a_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_valid || ((drive_number == 1'b0) && (track_number == '0)))
                    && (track_number <= 6'(MAX_HALF_TRACK / 2)))
      else $error("drive fields inconsistent");

endmodule

bind stepper_floppy_track_controller ftc_checker u_ftc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .read_data     (rsp_ch.read_data),
   .flush_request (rsp_ch.flush_request),
   .drive_valid   (rsp_ch.drive_valid),
   .drive_number  (rsp_ch.drive_number),
   .track_number  (rsp_ch.track_number),
   .flush_start   (rsp_ch.flush_start),
   .flush_count   (rsp_ch.flush_count)
);
